// File: rtl/core/otsm_pkg.sv
package otsm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 25;

	localparam int SQ_IN_W  = 48;
	localparam int SQ_OUT_W = 24;
	localparam int DV_N_W   = 27;
	localparam int DV_D_W   = 24;

	localparam logic [24:0] DEG360 = 25'd23592960;
	localparam logic [24:0] DEG180 = 25'd11796480;
	localparam logic [24:0] DEG90  = 25'd5898240;
	localparam logic [25:0] DEG720 = 26'd47185920;
	localparam logic signed [23:0] ELEV90 = 24'sd5898240;
	localparam logic signed [32:0] DEG180_FINE = 33'sd3019898880;

	typedef enum logic [2:0] {
		REG_TARGET_AZIMUTH   = 3'd0,
		REG_TARGET_ELEVATION = 3'd1,
		REG_PAN_STEP_SIZE    = 3'd2,
		REG_TILT_STEP_SIZE   = 3'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CLS_ZERO,
		CLS_180,
		CLS_POS90,
		CLS_NEG90,
		CLS_RIGHT,
		CLS_LEFT_POS,
		CLS_LEFT_NEG
	} ang_cls_t;

	typedef struct packed {
		logic [24:0]        target_azimuth;
		logic signed [23:0] target_elevation;
		logic [22:0]        pan_step_size;
		logic [22:0]        tilt_step_size;
	} cfg_t;

	typedef struct packed {
		ang_cls_t           hcls;
		ang_cls_t           ecls;
		logic signed [16:0] hy;
		logic signed [16:0] hx;
		logic signed [16:0] ax_neg;
		logic [31:0]        sumsq;
	} front_item_t;

	typedef struct packed {
		logic [24:0]        heading;
		logic signed [23:0] elevation;
		logic               pan_direction;
		logic [24:0]        pan_steps;
		logic               tilt_direction;
		logic [24:0]        tilt_steps;
	} res_t;

	function automatic logic signed [31:0] atan_fine(input int idx);
		logic signed [31:0] v;
		case (idx)
			0:  v = 32'sd754974720;
			1:  v = 32'sd445687602;
			2:  v = 32'sd235489089;
			3:  v = 32'sd119537938;
			4:  v = 32'sd60000934;
			5:  v = 32'sd30029717;
			6:  v = 32'sd15018523;
			7:  v = 32'sd7509720;
			8:  v = 32'sd3754917;
			9:  v = 32'sd1877466;
			10: v = 32'sd938734;
			11: v = 32'sd469367;
			12: v = 32'sd234684;
			13: v = 32'sd117342;
			14: v = 32'sd58671;
			15: v = 32'sd29335;
			16: v = 32'sd14668;
			17: v = 32'sd7334;
			18: v = 32'sd3667;
			19: v = 32'sd1833;
			20: v = 32'sd917;
			21: v = 32'sd458;
			22: v = 32'sd229;
			23: v = 32'sd115;
			24: v = 32'sd57;
			25: v = 32'sd29;
			26: v = 32'sd14;
			27: v = 32'sd7;
			28: v = 32'sd4;
			29: v = 32'sd2;
			30: v = 32'sd1;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/otsm_fifo.sv
module otsm_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty,
	output logic         full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign empty = (count_q == CW'(0));
	assign full  = (count_q == CW'(DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (wr && !rd) begin
				count_q <= count_q + CW'(1);
			end else if (rd && !wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/core/otsm_front.sv
module otsm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [15:0]    mag_x,
	input  logic signed [15:0]    mag_y,
	input  logic signed [15:0]    acc_x,
	input  logic signed [15:0]    acc_y,
	input  logic signed [15:0]    acc_z,
	input  logic                  q_full,
	output logic                  out_valid,
	output otsm_pkg::front_item_t out_item
);

	logic                  v_q;
	otsm_pkg::front_item_t item_q;
	otsm_pkg::front_item_t item_d;
	logic                  load;
	logic signed [31:0]    sq_y;
	logic signed [31:0]    sq_z;

	assign full      = v_q && q_full;
	assign load      = push && !full;
	assign out_valid = v_q;
	assign out_item  = item_q;

	assign sq_y = acc_y * acc_y;
	assign sq_z = acc_z * acc_z;

	always_comb begin
		item_d.sumsq  = unsigned'(sq_y) + unsigned'(sq_z);
		item_d.ax_neg = -{acc_x[15], acc_x};
		item_d.hy     = {mag_y[15], mag_y};
		item_d.hx     = {mag_x[15], mag_x};
		if (mag_y == 16'sd0) begin
			item_d.hcls = (mag_x < 16'sd0) ? otsm_pkg::CLS_180 : otsm_pkg::CLS_ZERO;
		end else if (mag_x == 16'sd0) begin
			item_d.hcls = (mag_y > 16'sd0) ? otsm_pkg::CLS_POS90 : otsm_pkg::CLS_NEG90;
		end else if (mag_x > 16'sd0) begin
			item_d.hcls = otsm_pkg::CLS_RIGHT;
		end else begin
			item_d.hcls = (mag_y > 16'sd0) ? otsm_pkg::CLS_LEFT_POS : otsm_pkg::CLS_LEFT_NEG;
			item_d.hy   = -{mag_y[15], mag_y};
			item_d.hx   = -{mag_x[15], mag_x};
		end
		if (acc_x == 16'sd0) begin
			item_d.ecls = otsm_pkg::CLS_ZERO;
		end else if (item_d.sumsq == 32'd0) begin
			item_d.ecls = (acc_x < 16'sd0) ? otsm_pkg::CLS_POS90 : otsm_pkg::CLS_NEG90;
		end else begin
			item_d.ecls = otsm_pkg::CLS_RIGHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= load || (v_q && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_d;
		end
	end

endmodule

// File: rtl/core/otsm_isqrt.sv
module otsm_isqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [SIDE_W-1:0]            in_side,
	input  logic [otsm_pkg::SQ_IN_W-1:0] in_n,
	output logic                         out_valid,
	output logic [SIDE_W-1:0]            out_side,
	output logic [otsm_pkg::SQ_OUT_W-1:0] out_root
);

	localparam int NS  = otsm_pkg::SQ_OUT_W;
	localparam int NW  = otsm_pkg::SQ_IN_W;
	localparam int RW  = NS + 2;
	localparam int TW  = RW + 2;

	logic [NS-1:0]     v_q;
	logic [SIDE_W-1:0] side_q [NS];
	logic [NW-1:0]     n_q    [NS];
	logic [RW-1:0]     rem_q  [NS];
	logic [NS-1:0]     root_q [NS];

	for (genvar i = 0; i < NS; i++) begin : g_stage
		logic              cv;
		logic [SIDE_W-1:0] cs;
		logic [NW-1:0]     cn;
		logic [RW-1:0]     crem;
		logic [NS-1:0]     croot;
		logic [TW-1:0]     tmp;
		logic [TW-1:0]     trial;

		if (i == 0) begin : g_first
			assign cv    = in_valid;
			assign cs    = in_side;
			assign cn    = in_n;
			assign crem  = '0;
			assign croot = '0;
		end else begin : g_next
			assign cv    = v_q[i-1];
			assign cs    = side_q[i-1];
			assign cn    = n_q[i-1];
			assign crem  = rem_q[i-1];
			assign croot = root_q[i-1];
		end

		assign tmp   = {crem, cn[NW-1:NW-2]};
		assign trial = {2'b00, croot, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i] <= cs;
				n_q[i]    <= {cn[NW-3:0], 2'b00};
				if (tmp >= trial) begin
					rem_q[i]  <= RW'(tmp - trial);
					root_q[i] <= {croot[NS-2:0], 1'b1};
				end else begin
					rem_q[i]  <= RW'(tmp);
					root_q[i] <= {croot[NS-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_q[NS-1];
	assign out_side  = side_q[NS-1];
	assign out_root  = root_q[NS-1];

endmodule

// File: rtl/core/otsm_cordic.sv
module otsm_cordic #(
	parameter int ITER   = 24,
	parameter int SIDE_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [SIDE_W-1:0]  in_side,
	input  logic signed [63:0] in_y,
	input  logic signed [63:0] in_x,
	output logic               out_valid,
	output logic [SIDE_W-1:0]  out_side,
	output logic signed [31:0] out_z
);

	logic [ITER-1:0]    v_q;
	logic [SIDE_W-1:0]  side_q [ITER];
	logic signed [63:0] x_q    [ITER];
	logic signed [63:0] y_q    [ITER];
	logic signed [31:0] z_q    [ITER];

	for (genvar i = 0; i < ITER; i++) begin : g_stage
		logic               cv;
		logic [SIDE_W-1:0]  cs;
		logic signed [63:0] cx;
		logic signed [63:0] cy;
		logic signed [31:0] cz;
		logic signed [63:0] dx;
		logic signed [63:0] dy;

		if (i == 0) begin : g_first
			assign cv = in_valid;
			assign cs = in_side;
			assign cx = in_x;
			assign cy = in_y;
			assign cz = '0;
		end else begin : g_next
			assign cv = v_q[i-1];
			assign cs = side_q[i-1];
			assign cx = x_q[i-1];
			assign cy = y_q[i-1];
			assign cz = z_q[i-1];
		end

		assign dx = cy >>> i;
		assign dy = cx >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i] <= cs;
				if (cy > 64'sd0) begin
					x_q[i] <= cx + dx;
					y_q[i] <= cy - dy;
					z_q[i] <= cz + otsm_pkg::atan_fine(i);
				end else begin
					x_q[i] <= cx - dx;
					y_q[i] <= cy + dy;
					z_q[i] <= cz - otsm_pkg::atan_fine(i);
				end
			end
		end
	end

	assign out_valid = v_q[ITER-1];
	assign out_side  = side_q[ITER-1];
	assign out_z     = z_q[ITER-1];

endmodule

// File: rtl/core/otsm_div.sv
module otsm_div #(
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [SIDE_W-1:0]           in_side,
	input  logic [otsm_pkg::DV_N_W-1:0] in_n,
	input  logic [otsm_pkg::DV_D_W-1:0] in_d,
	output logic                        out_valid,
	output logic [SIDE_W-1:0]           out_side,
	output logic [otsm_pkg::DV_N_W-1:0] out_q
);

	localparam int NW = otsm_pkg::DV_N_W;
	localparam int DW = otsm_pkg::DV_D_W;

	logic [NW-1:0]     v_q;
	logic [SIDE_W-1:0] side_q [NW];
	logic [NW-1:0]     n_q    [NW];
	logic [DW-1:0]     d_q    [NW];
	logic [DW-1:0]     rem_q  [NW];
	logic [NW-1:0]     quo_q  [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic              cv;
		logic [SIDE_W-1:0] cs;
		logic [NW-1:0]     cn;
		logic [DW-1:0]     cd;
		logic [DW-1:0]     crem;
		logic [NW-1:0]     cquo;
		logic [DW:0]       tmp;

		if (i == 0) begin : g_first
			assign cv   = in_valid;
			assign cs   = in_side;
			assign cn   = in_n;
			assign cd   = in_d;
			assign crem = '0;
			assign cquo = '0;
		end else begin : g_next
			assign cv   = v_q[i-1];
			assign cs   = side_q[i-1];
			assign cn   = n_q[i-1];
			assign cd   = d_q[i-1];
			assign crem = rem_q[i-1];
			assign cquo = quo_q[i-1];
		end

		assign tmp = {crem, cn[NW-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i] <= 1'b0;
			end else if (en) begin
				v_q[i] <= cv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[i] <= cs;
				n_q[i]    <= {cn[NW-2:0], 1'b0};
				d_q[i]    <= cd;
				if (tmp >= {1'b0, cd}) begin
					rem_q[i] <= DW'(tmp - {1'b0, cd});
					quo_q[i] <= {cquo[NW-2:0], 1'b1};
				end else begin
					rem_q[i] <= DW'(tmp);
					quo_q[i] <= {cquo[NW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_q[NW-1];
	assign out_side  = side_q[NW-1];
	assign out_q     = quo_q[NW-1];

endmodule

// File: rtl/core/otsm_back.sv
module otsm_back #(
	parameter int ITER = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  otsm_pkg::front_item_t in_item,
	input  otsm_pkg::cfg_t        cfg,
	output logic                  out_valid,
	output otsm_pkg::res_t        out_res
);

	typedef struct packed {
		otsm_pkg::ang_cls_t hcls;
		otsm_pkg::ang_cls_t ecls;
		logic signed [16:0] hy;
		logic signed [16:0] hx;
		logic signed [16:0] ax_neg;
	} sq_side_t;

	typedef struct packed {
		logic [24:0]        heading;
		logic signed [23:0] elevation;
		logic               pan_direction;
		logic               tilt_direction;
	} dv_side_t;

	sq_side_t                         sq_in_side;
	sq_side_t                         sq_out_side;
	logic                             sq_out_valid;
	logic [otsm_pkg::SQ_OUT_W-1:0]    root;
	logic signed [63:0]               h_y;
	logic signed [63:0]               h_x;
	logic signed [63:0]               e_y;
	logic signed [63:0]               e_x;
	logic                             co_valid;
	otsm_pkg::ang_cls_t               co_hcls;
	otsm_pkg::ang_cls_t               co_ecls;
	logic signed [31:0]               hz;
	logic signed [31:0]               ez;

	logic [8:1]                       v_q;
	otsm_pkg::ang_cls_t               hcls_s1, hcls_s2, hcls_s3;
	otsm_pkg::ang_cls_t               ecls_s1, ecls_s2, ecls_s3;
	logic signed [32:0]               hz_s1, ez_s1;
	logic                             hneg_s2, eneg_s2, hneg_s3, eneg_s3;
	logic [32:0]                      habs_s2, eabs_s2;
	logic [24:0]                      hm_s3, em_s3;
	logic [24:0]                      heading_s4;
	logic signed [23:0]               elev_s4;
	logic [25:0]                      d_s5;
	logic signed [24:0]               dt_s5;
	logic [24:0]                      heading_s5, heading_s6, heading_s7, heading_s8;
	logic signed [23:0]               elev_s5, elev_s6, elev_s7, elev_s8;
	logic [24:0]                      r_s6;
	logic                             tdir_s6, tdir_s7, tdir_s8;
	logic [23:0]                      tmag_s6, tmag_s7;
	logic                             pdir_s7, pdir_s8;
	logic [24:0]                      pmag_s7;
	logic [otsm_pkg::DV_N_W-1:0]      pn_s8, tn_s8;
	logic [otsm_pkg::DV_D_W-1:0]      pd_s8, td_s8;

	logic [33:0]                      hsum;
	logic [33:0]                      esum;
	logic [24:0]                      heading_d;
	logic signed [23:0]               elev_d;
	logic [22:0]                      pstep;
	logic [22:0]                      tstep;
	dv_side_t                         dv_in_side;
	dv_side_t                         dv_out_side;
	logic                             dv_valid;
	logic [otsm_pkg::DV_N_W-1:0]      pq;
	logic [otsm_pkg::DV_N_W-1:0]      tq;

	assign sq_in_side.hcls   = in_item.hcls;
	assign sq_in_side.ecls   = in_item.ecls;
	assign sq_in_side.hy     = in_item.hy;
	assign sq_in_side.hx     = in_item.hx;
	assign sq_in_side.ax_neg = in_item.ax_neg;

	otsm_isqrt #(
		.SIDE_W($bits(sq_side_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.in_side  (sq_in_side),
		.in_n     ({in_item.sumsq, 16'b0}),
		.out_valid(sq_out_valid),
		.out_side (sq_out_side),
		.out_root (root)
	);

	assign h_y = {{7{sq_out_side.hy[16]}}, sq_out_side.hy, 40'b0};
	assign h_x = {{7{sq_out_side.hx[16]}}, sq_out_side.hx, 40'b0};
	assign e_y = {{7{sq_out_side.ax_neg[16]}}, sq_out_side.ax_neg, 40'b0};
	assign e_x = {8'b0, root, 32'b0};

	otsm_cordic #(
		.ITER  (ITER),
		.SIDE_W($bits(otsm_pkg::ang_cls_t))
	) u_cordic_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_out_valid),
		.in_side  (sq_out_side.hcls),
		.in_y     (h_y),
		.in_x     (h_x),
		.out_valid(co_valid),
		.out_side (co_hcls),
		.out_z    (hz)
	);

	otsm_cordic #(
		.ITER  (ITER),
		.SIDE_W($bits(otsm_pkg::ang_cls_t))
	) u_cordic_elev (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_out_valid),
		.in_side  (sq_out_side.ecls),
		.in_y     (e_y),
		.in_x     (e_x),
		.out_valid(),
		.out_side (co_ecls),
		.out_z    (ez)
	);

	assign hsum = {1'b0, habs_s2} + 34'd128;
	assign esum = {1'b0, eabs_s2} + 34'd128;

	always_comb begin
		case (hcls_s3)
			otsm_pkg::CLS_ZERO:  heading_d = '0;
			otsm_pkg::CLS_180:   heading_d = otsm_pkg::DEG180;
			otsm_pkg::CLS_POS90: heading_d = otsm_pkg::DEG90;
			otsm_pkg::CLS_NEG90: heading_d = otsm_pkg::DEG360 - otsm_pkg::DEG90;
			default: begin
				heading_d = (hneg_s3 && hm_s3 != 25'd0) ? otsm_pkg::DEG360 - hm_s3 : hm_s3;
			end
		endcase
		case (ecls_s3)
			otsm_pkg::CLS_ZERO:  elev_d = '0;
			otsm_pkg::CLS_POS90: elev_d = otsm_pkg::ELEV90;
			otsm_pkg::CLS_NEG90: elev_d = -otsm_pkg::ELEV90;
			default: begin
				elev_d = eneg_s3 ? -signed'(em_s3[23:0]) : signed'(em_s3[23:0]);
			end
		endcase
	end

	assign pstep = (cfg.pan_step_size == 23'd0) ? 23'd1 : cfg.pan_step_size;
	assign tstep = (cfg.tilt_step_size == 23'd0) ? 23'd1 : cfg.tilt_step_size;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[7:1], co_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hcls_s1 <= co_hcls;
			ecls_s1 <= co_ecls;
			case (co_hcls)
				otsm_pkg::CLS_LEFT_POS: hz_s1 <= {hz[31], hz} + otsm_pkg::DEG180_FINE;
				otsm_pkg::CLS_LEFT_NEG: hz_s1 <= {hz[31], hz} - otsm_pkg::DEG180_FINE;
				default:                hz_s1 <= {hz[31], hz};
			endcase
			ez_s1 <= {ez[31], ez};

			hcls_s2 <= hcls_s1;
			ecls_s2 <= ecls_s1;
			hneg_s2 <= hz_s1[32];
			eneg_s2 <= ez_s1[32];
			habs_s2 <= hz_s1[32] ? unsigned'(-hz_s1) : unsigned'(hz_s1);
			eabs_s2 <= ez_s1[32] ? unsigned'(-ez_s1) : unsigned'(ez_s1);

			hcls_s3 <= hcls_s2;
			ecls_s3 <= ecls_s2;
			hneg_s3 <= hneg_s2;
			eneg_s3 <= eneg_s2;
			hm_s3   <= hsum[32:8];
			em_s3   <= esum[32:8];

			heading_s4 <= heading_d;
			elev_s4    <= elev_d;

			heading_s5 <= heading_s4;
			elev_s5    <= elev_s4;
			d_s5       <= {1'b0, cfg.target_azimuth} + {1'b0, otsm_pkg::DEG360}
			              - {1'b0, heading_s4};
			dt_s5      <= {elev_s4[23], elev_s4}
			              - {cfg.target_elevation[23], cfg.target_elevation};

			heading_s6 <= heading_s5;
			elev_s6    <= elev_s5;
			if (d_s5 >= otsm_pkg::DEG720) begin
				r_s6 <= 25'(d_s5 - otsm_pkg::DEG720);
			end else if (d_s5 >= {1'b0, otsm_pkg::DEG360}) begin
				r_s6 <= 25'(d_s5 - {1'b0, otsm_pkg::DEG360});
			end else begin
				r_s6 <= d_s5[24:0];
			end
			tdir_s6 <= !dt_s5[24];
			tmag_s6 <= dt_s5[24] ? 24'(-dt_s5) : dt_s5[23:0];

			heading_s7 <= heading_s6;
			elev_s7    <= elev_s6;
			tdir_s7    <= tdir_s6;
			tmag_s7    <= tmag_s6;
			pdir_s7    <= (r_s6 == 25'd0);
			pmag_s7    <= (r_s6 == 25'd0) ? 25'd0 : otsm_pkg::DEG360 - r_s6;

			heading_s8 <= heading_s7;
			elev_s8    <= elev_s7;
			tdir_s8    <= tdir_s7;
			pdir_s8    <= pdir_s7;
			pn_s8      <= {1'b0, pmag_s7, 1'b0} + {4'b0, pstep};
			pd_s8      <= {pstep, 1'b0};
			tn_s8      <= {2'b0, tmag_s7, 1'b0} + {4'b0, tstep};
			td_s8      <= {tstep, 1'b0};
		end
	end

	assign dv_in_side.heading        = heading_s8;
	assign dv_in_side.elevation      = elev_s8;
	assign dv_in_side.pan_direction  = pdir_s8;
	assign dv_in_side.tilt_direction = tdir_s8;

	otsm_div #(
		.SIDE_W($bits(dv_side_t))
	) u_div_pan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_q[8]),
		.in_side  (dv_in_side),
		.in_n     (pn_s8),
		.in_d     (pd_s8),
		.out_valid(dv_valid),
		.out_side (dv_out_side),
		.out_q    (pq)
	);

	otsm_div #(
		.SIDE_W(1)
	) u_div_tilt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_q[8]),
		.in_side  (1'b0),
		.in_n     (tn_s8),
		.in_d     (td_s8),
		.out_valid(),
		.out_side (),
		.out_q    (tq)
	);

	assign out_valid              = dv_valid;
	assign out_res.heading        = dv_out_side.heading;
	assign out_res.elevation      = dv_out_side.elevation;
	assign out_res.pan_direction  = dv_out_side.pan_direction;
	assign out_res.pan_steps      = pq[24:0];
	assign out_res.tilt_direction = dv_out_side.tilt_direction;
	assign out_res.tilt_steps     = tq[24:0];

endmodule

// File: rtl/core/orientation_to_step_move_core.sv
// Channel   Direction  Handshake             Payload
// input     in         push / full           mag_x, mag_y, acc_x, acc_y, acc_z
// result    out        empty / pop           heading, elevation, pan/tilt direction and steps
// config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request is taken per cycle while full is low, and each gives one result. The edge
// that accepts a request loads the front register. The request then passes through the
// front queue, 24 square-root stages, the CORDIC stages, 8 finishing stages and 27 divider
// stages into the result queue.
// Reset clears all valid state; configuration registers return to their documented defaults.
// When the result queue is full and not popped, the whole back pipeline holds and the front
// queue fills, after which full is raised.
module orientation_to_step_move_core #(
	parameter int CORDIC_ITERATIONS = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic signed [15:0]               mag_x,
	input  logic signed [15:0]               mag_y,
	input  logic signed [15:0]               acc_x,
	input  logic signed [15:0]               acc_y,
	input  logic signed [15:0]               acc_z,
	output logic                             empty,
	input  logic                             pop,
	output logic [24:0]                      heading,
	output logic signed [23:0]               elevation,
	output logic                             pan_direction,
	output logic [24:0]                      pan_steps,
	output logic                             tilt_direction,
	output logic [24:0]                      tilt_steps,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [otsm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [otsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	otsm_pkg::cfg_t        cfg_q;
	logic                  f_valid;
	otsm_pkg::front_item_t f_item;
	logic                  q_full;
	logic                  q_empty;
	logic                  q_push;
	logic                  q_pop;
	otsm_pkg::front_item_t q_item;
	logic                  adv;
	logic                  b_valid;
	otsm_pkg::res_t        b_res;
	logic                  o_full;
	logic                  o_pop;
	otsm_pkg::res_t        o_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_azimuth   <= 25'd11796480;
			cfg_q.target_elevation <= 24'sd2949120;
			cfg_q.pan_step_size    <= 23'd1024;
			cfg_q.tilt_step_size   <= 23'd1024;
		end else if (cfg_valid && cfg_ready) begin
			case (otsm_pkg::cfg_reg_t'(cfg_index))
				otsm_pkg::REG_TARGET_AZIMUTH:   cfg_q.target_azimuth   <= cfg_data;
				otsm_pkg::REG_TARGET_ELEVATION: cfg_q.target_elevation <= signed'(cfg_data[23:0]);
				otsm_pkg::REG_PAN_STEP_SIZE:    cfg_q.pan_step_size    <= cfg_data[22:0];
				otsm_pkg::REG_TILT_STEP_SIZE:   cfg_q.tilt_step_size   <= cfg_data[22:0];
				default: ;
			endcase
		end
	end

	otsm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.mag_x    (mag_x),
		.mag_y    (mag_y),
		.acc_x    (acc_x),
		.acc_y    (acc_y),
		.acc_z    (acc_z),
		.q_full   (q_full),
		.out_valid(f_valid),
		.out_item (f_item)
	);

	assign q_push = f_valid && !q_full;

	otsm_fifo #(
		.W    ($bits(otsm_pkg::front_item_t)),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (q_push),
		.wdata (f_item),
		.rd    (q_pop),
		.rdata (q_item),
		.empty (q_empty),
		.full  (q_full)
	);

	assign o_pop = pop && !empty;
	assign adv   = !o_full || o_pop;
	assign q_pop = adv && !q_empty;

	otsm_back #(
		.ITER(CORDIC_ITERATIONS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (!q_empty),
		.in_item  (q_item),
		.cfg      (cfg_q),
		.out_valid(b_valid),
		.out_res  (b_res)
	);

	otsm_fifo #(
		.W    ($bits(otsm_pkg::res_t)),
		.DEPTH(2)
	) u_result (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (b_valid && adv),
		.wdata (b_res),
		.rd    (o_pop),
		.rdata (o_res),
		.empty (empty),
		.full  (o_full)
	);

	assign heading        = o_res.heading;
	assign elevation      = o_res.elevation;
	assign pan_direction  = o_res.pan_direction;
	assign pan_steps      = o_res.pan_steps;
	assign tilt_direction = o_res.tilt_direction;
	assign tilt_steps     = o_res.tilt_steps;

endmodule

// File: rtl/core/otsm_checker.sv
module otsm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            empty,
	input logic                            pop,
	input logic [24:0]                     heading,
	input logic signed [23:0]              elevation,
	input logic                            pan_direction,
	input logic [24:0]                     pan_steps,
	input logic [24:0]                     tilt_steps
);

	// A waiting result that is not taken stays in place.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(heading) && $stable(pan_steps)
			&& $stable(tilt_steps)))
		else $error("result changed while waiting");

	// A zero azimuth delta means no pan steps.
	a_pan_dir_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pan_direction) |-> (pan_steps == 25'd0))
		else $error("pan direction set with nonzero steps");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (heading < otsm_pkg::DEG360))
		else $error("heading out of range");

	a_elev_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (elevation <= otsm_pkg::ELEV90 && elevation >= -otsm_pkg::ELEV90))
		else $error("elevation out of range");

endmodule

bind orientation_to_step_move_core otsm_checker u_otsm_checker (.*);

// File: verif/orientation_to_step_move_core_tb.sv
module orientation_to_step_move_core_tb;

	localparam int ITERS = 24;
	localparam int DRAIN_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint FULL_TURN = 64'sd23592960;
	localparam longint HALF_TURN = 64'sd11796480;
	localparam longint QUARTER_TURN = 64'sd5898240;

	typedef struct packed {
		logic signed [15:0] mx;
		logic signed [15:0] my;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [15:0] mag_x = '0, mag_y = '0, acc_x = '0, acc_y = '0, acc_z = '0;
	logic empty;
	logic pop = 1'b0;
	logic [24:0] heading;
	logic signed [23:0] elevation;
	logic pan_direction;
	logic [24:0] pan_steps;
	logic tilt_direction;
	logic [24:0] tilt_steps;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [otsm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [otsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	otsm_pkg::cfg_t model_cfg;
	reading_t pending_readings[$];
	otsm_pkg::res_t expected_moves[$];
	int errors = 0;
	int requests_sent = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_for_drain = 0;
	logic [7:0] stall_lfsr = 8'hA5;

	orientation_to_step_move_core #(.CORDIC_ITERATIONS(ITERS)) u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.mag_x(mag_x), .mag_y(mag_y), .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
		.empty(empty), .pop(pop), .heading(heading), .elevation(elevation),
		.pan_direction(pan_direction), .pan_steps(pan_steps),
		.tilt_direction(tilt_direction), .tilt_steps(tilt_steps),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint shift_down(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint vector_angle(longint yi, longint xi);
		longint x, y, z, dx, dy, m;
		logic flip;
		if (yi == 0)
			return (xi < 0) ? HALF_TURN : 0;
		if (xi == 0)
			return (yi > 0) ? QUARTER_TURN : -QUARTER_TURN;
		flip = (xi < 0);
		x = flip ? -xi : xi;
		y = flip ? -yi : yi;
		z = 0;
		for (int i = 0; i < ITERS && i < 32; i++) begin
			dx = shift_down(y, i);
			dy = shift_down(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += longint'(otsm_pkg::atan_fine(i));
			end else begin
				x -= dx; y += dy; z -= longint'(otsm_pkg::atan_fine(i));
			end
		end
		if (flip)
			z += (yi > 0) ? (64'sd180 <<< 24) : -(64'sd180 <<< 24);
		m = (z < 0) ? -z : z;
		m = (m + 128) >>> 8;
		return (z < 0) ? -m : m;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res, one;
		res = 0;
		one = 64'd1 << 62;
		while (one > n)
			one >>= 2;
		while (one != 0) begin
			if (n >= res + one) begin
				n -= res + one;
				res = (res >> 1) + one;
			end else begin
				res >>= 1;
			end
			one >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic logic [24:0] step_count(longint mag, logic [22:0] step);
		longint s;
		s = (step == 0) ? 1 : longint'(step);
		return 25'((2 * mag + s) / (2 * s));
	endfunction

	function automatic otsm_pkg::res_t predict_move(reading_t rd, otsm_pkg::cfg_t c);
		otsm_pkg::res_t r;
		longint head, elev, root, d, rem, dpan, dtilt;
		longint unsigned sumsq;
		head = vector_angle(longint'(rd.my) <<< 40, longint'(rd.mx) <<< 40);
		if (head < 0)
			head += FULL_TURN;
		sumsq = longint'(rd.ay) * rd.ay + longint'(rd.az) * rd.az;
		root = int_sqrt(sumsq << 16);
		elev = vector_angle((-longint'(rd.ax) * 256) <<< 32, root <<< 32);
		d = longint'(c.target_azimuth) - head + FULL_TURN;
		rem = d % FULL_TURN;
		dpan = (rem > 0) ? rem - FULL_TURN : rem;
		dtilt = elev - longint'(c.target_elevation);
		r.heading = 25'(head);
		r.elevation = 24'(elev);
		r.pan_direction = (dpan >= 0);
		r.pan_steps = step_count((dpan < 0) ? -dpan : dpan, c.pan_step_size);
		r.tilt_direction = (dtilt >= 0);
		r.tilt_steps = step_count((dtilt < 0) ? -dtilt : dtilt, c.tilt_step_size);
		return r;
	endfunction

	function automatic reading_t random_reading();
		reading_t rd;
		int mode;
		rd = reading_t'(80'({$urandom, $urandom, $urandom}));
		mode = $urandom_range(0, 9);
		if (mode == 0) rd.my = '0;
		if (mode == 1) rd.mx = '0;
		if (mode == 2) begin rd.ay = '0; rd.az = '0; end
		if (mode == 3) rd.ax = '0;
		if (mode == 4) begin
			rd.mx = 16'($signed($urandom_range(0, 40)) - 20);
			rd.my = 16'($signed($urandom_range(0, 40)) - 20);
			rd.ax = 16'($signed($urandom_range(0, 40)) - 20);
		end
		return rd;
	endfunction

	task automatic write_reg(otsm_pkg::cfg_reg_t idx, logic [otsm_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			otsm_pkg::REG_TARGET_AZIMUTH:   model_cfg.target_azimuth = value[24:0];
			otsm_pkg::REG_TARGET_ELEVATION: model_cfg.target_elevation = value[23:0];
			otsm_pkg::REG_PAN_STEP_SIZE:    model_cfg.pan_step_size = value[22:0];
			otsm_pkg::REG_TILT_STEP_SIZE:   model_cfg.tilt_step_size = value[22:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_readings.size() != 0 || expected_moves.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int count);
		reading_t rd;
		for (int i = 0; i < count; i++) begin
			rd = random_reading();
			pending_readings.push_back(rd);
		end
		wait_idle();
	endtask

	always @(negedge clk) begin
		if (!arst_n || hold_for_drain != 0) begin
			push <= 1'b0;
		end else begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				push <= 1'b0;
			end else if (pending_readings.size() != 0) begin
				mag_x <= pending_readings[0].mx;
				mag_y <= pending_readings[0].my;
				acc_x <= pending_readings[0].ax;
				acc_y <= pending_readings[0].ay;
				acc_z <= pending_readings[0].az;
				push <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				push <= 1'b0;
			end
		end
		stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
		pop <= arst_n && (stall_lfsr[7:6] != 2'b00 || stall_lfsr[2]);
	end

	always @(posedge clk) begin
		otsm_pkg::res_t exp_r;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (push && !full) begin
				reading_t rd;
				rd = pending_readings.pop_front();
				expected_moves.push_back(predict_move(rd, model_cfg));
				requests_sent++;
				moved = 1'b1;
			end
			if (pop && !empty) begin
				moved = 1'b1;
				results_seen++;
				if (expected_moves.size() == 0) begin
					$display("%0t: unexpected result heading=%0d", $time, heading);
					errors++;
				end else begin
					exp_r = expected_moves.pop_front();
					if (exp_r.heading !== heading) begin
						$display("%0t: heading exp %0d got %0d", $time, exp_r.heading, heading);
						errors++;
					end
					if (exp_r.elevation !== elevation) begin
						$display("%0t: elevation exp %0d got %0d", $time, exp_r.elevation,
							elevation);
						errors++;
					end
					if (exp_r.pan_direction !== pan_direction) begin
						$display("%0t: pan_direction exp %0d got %0d", $time,
							exp_r.pan_direction, pan_direction);
						errors++;
					end
					if (exp_r.pan_steps !== pan_steps) begin
						$display("%0t: pan_steps exp %0d got %0d", $time, exp_r.pan_steps,
							pan_steps);
						errors++;
					end
					if (exp_r.tilt_direction !== tilt_direction) begin
						$display("%0t: tilt_direction exp %0d got %0d", $time,
							exp_r.tilt_direction, tilt_direction);
						errors++;
					end
					if (exp_r.tilt_steps !== tilt_steps) begin
						$display("%0t: tilt_steps exp %0d got %0d", $time, exp_r.tilt_steps,
							tilt_steps);
						errors++;
					end
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		reading_t rd;
		model_cfg.target_azimuth = 25'd11796480;
		model_cfg.target_elevation = 24'sd2949120;
		model_cfg.pan_step_size = 23'd1024;
		model_cfg.tilt_step_size = 23'd1024;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Axis vectors, all-zero pairs, both half planes and field extremes.
		pending_readings.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_readings.push_back('{16'sd100, 16'sd0, -16'sd300, 16'sd0, 16'sd200});
		pending_readings.push_back('{-16'sd100, 16'sd0, 16'sd300, 16'sd50, 16'sd0});
		pending_readings.push_back('{16'sd0, 16'sd77, 16'sd0, 16'sd0, 16'sd0});
		pending_readings.push_back('{16'sd0, -16'sd77, 16'sd5, 16'sd0, 16'sd0});
		pending_readings.push_back('{-16'sd5, 16'sd9, -16'sd5, 16'sd0, 16'sd0});
		pending_readings.push_back('{-16'sd5, -16'sd9, 16'sd1, 16'sd1, 16'sd1});
		pending_readings.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
		pending_readings.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
			-16'sd32768});
		pending_readings.push_back('{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd0});
		pending_readings.push_back('{16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, 16'sd32767});
		pending_readings.push_back('{16'sd1, -16'sd1, 16'sd0, 16'sd0, -16'sd1});
		pending_readings.push_back('{-16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'sd0});
		wait_idle();
		run_phase(150);

		write_reg(otsm_pkg::REG_TARGET_AZIMUTH, 25'd0);
		write_reg(otsm_pkg::REG_TARGET_ELEVATION, 25'(-24'sd5898240));
		write_reg(otsm_pkg::REG_PAN_STEP_SIZE, 25'd1);
		write_reg(otsm_pkg::REG_TILT_STEP_SIZE, 25'd1);
		write_reg(otsm_pkg::cfg_reg_t'(3'd5), 25'h1FFFFFF);
		run_phase(250);

		write_reg(otsm_pkg::REG_TARGET_AZIMUTH, 25'd23592959);
		write_reg(otsm_pkg::REG_TARGET_ELEVATION, 25'd5898240);
		write_reg(otsm_pkg::REG_PAN_STEP_SIZE, 25'd4194304);
		write_reg(otsm_pkg::REG_TILT_STEP_SIZE, 25'd4194304);
		run_phase(150);

		hold_for_drain = 1;
		write_reg(otsm_pkg::REG_TARGET_AZIMUTH, 25'h1FFFFFF);
		write_reg(otsm_pkg::REG_TARGET_ELEVATION, 25'h0800000);
		write_reg(otsm_pkg::REG_PAN_STEP_SIZE, 25'd0);
		write_reg(otsm_pkg::REG_TILT_STEP_SIZE, 25'h07FFFFF);
		for (int i = 0; i < 200; i++) begin
			rd = random_reading();
			pending_readings.push_back(rd);
		end
		repeat (30) @(posedge clk);
		hold_for_drain = 0;
		wait_idle();

		for (int p = 0; p < 3; p++) begin
			write_reg(otsm_pkg::REG_TARGET_AZIMUTH, 25'($urandom_range(0, 23592959)));
			write_reg(otsm_pkg::REG_TARGET_ELEVATION,
				25'($signed($urandom_range(0, 11796480)) - 5898240));
			write_reg(otsm_pkg::REG_PAN_STEP_SIZE, 25'($urandom_range(1, 70000)));
			write_reg(otsm_pkg::REG_TILT_STEP_SIZE, 25'($urandom_range(1, 70000)));
			run_phase(200);
		end

		$display("Sent %0d readings and checked %0d results over seven register settings.",
			requests_sent, results_seen);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
